// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the RTL top level.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted (active-low reset).
`define PSL_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that stays armed through reset.
`define PSL_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hw/rtl/psl_pkg.sv =====
// Shared types, constants and microcode for the PID steering unit.
// No dependencies; used by psl_div, the top level and the testbench.
package psl_pkg;

  localparam int unsigned DIV_W   = 11;
  localparam int unsigned QUO_W   = 15;
  localparam int unsigned CNT_W   = 4;
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(QUO_W - 1);

  localparam int unsigned Q_W     = 16;
  localparam int unsigned OUT_W   = 48;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned ADDR_W  = 3;
  localparam int unsigned PC_W    = 4;

  localparam logic [2:0] ST_CENTER    = 3'd0;
  localparam logic [2:0] ST_RIGHT     = 3'd1;
  localparam logic [2:0] ST_LEFT      = 3'd2;
  localparam logic [2:0] ST_SEARCHING = 3'd3;
  localparam logic [2:0] ST_STOPPED   = 3'd4;

  localparam logic [ADDR_W-1:0] REG_GAIN_P       = 3'd0;
  localparam logic [ADDR_W-1:0] REG_GAIN_I       = 3'd1;
  localparam logic [ADDR_W-1:0] REG_GAIN_D       = 3'd2;
  localparam logic [ADDR_W-1:0] REG_CRUISE_SPEED = 3'd3;
  localparam logic [ADDR_W-1:0] REG_LOST_TIMEOUT = 3'd4;
  localparam logic [ADDR_W-1:0] REG_IMAGE_WIDTH  = 3'd5;

  localparam logic [PC_W-1:0] STEP_WAIT  = 4'd0;
  localparam logic [PC_W-1:0] STEP_CHECK = 4'd1;
  localparam logic [PC_W-1:0] STEP_DIVE  = 4'd2;
  localparam logic [PC_W-1:0] STEP_EMITF = 4'd10;
  localparam logic [PC_W-1:0] STEP_EMITL = 4'd11;

  typedef enum logic [3:0] {
    OP_WAIT,
    OP_SETUP_ERR,
    OP_DIV,
    OP_ERR,
    OP_INTEG,
    OP_MAC_P,
    OP_MAC_I,
    OP_MAC_D,
    OP_SETUP_ANG,
    OP_SCALE,
    OP_EMIT_FOUND,
    OP_EMIT_LOST
  } op_e;

  typedef enum logic [2:0] {
    COND_NONE,
    COND_NO_ACCEPT,
    COND_LOST,
    COND_DIV_BUSY,
    COND_OUT_BUSY
  } cond_e;

  typedef struct packed {
    op_e             op;
    cond_e           cond;
    logic [PC_W-1:0] target;
    logic            ret;
  } ucode_t;

  typedef struct packed {
    logic load;
    logic step;
  } div_ctl_t;

  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t cw;
    cw = '{op: OP_WAIT, cond: COND_NONE, target: STEP_WAIT, ret: 1'b1};
    unique case (pc)
      4'd0:  cw = '{op: OP_WAIT,       cond: COND_NO_ACCEPT, target: STEP_WAIT,  ret: 1'b0};
      4'd1:  cw = '{op: OP_SETUP_ERR,  cond: COND_LOST,      target: STEP_EMITL, ret: 1'b0};
      4'd2:  cw = '{op: OP_DIV,        cond: COND_DIV_BUSY,  target: STEP_DIVE,  ret: 1'b0};
      4'd3:  cw = '{op: OP_ERR,        cond: COND_NONE,      target: STEP_WAIT,  ret: 1'b0};
      4'd4:  cw = '{op: OP_INTEG,      cond: COND_NONE,      target: STEP_WAIT,  ret: 1'b0};
      4'd5:  cw = '{op: OP_MAC_P,      cond: COND_NONE,      target: STEP_WAIT,  ret: 1'b0};
      4'd6:  cw = '{op: OP_MAC_I,      cond: COND_NONE,      target: STEP_WAIT,  ret: 1'b0};
      4'd7:  cw = '{op: OP_MAC_D,      cond: COND_NONE,      target: STEP_WAIT,  ret: 1'b0};
      4'd8:  cw = '{op: OP_SETUP_ANG,  cond: COND_NONE,      target: STEP_WAIT,  ret: 1'b0};
      4'd9:  cw = '{op: OP_SCALE,      cond: COND_NONE,      target: STEP_WAIT,  ret: 1'b0};
      4'd10: cw = '{op: OP_EMIT_FOUND, cond: COND_OUT_BUSY,  target: STEP_EMITF, ret: 1'b1};
      4'd11: cw = '{op: OP_EMIT_LOST,  cond: COND_OUT_BUSY,  target: STEP_EMITL, ret: 1'b1};
      default: cw = '{op: OP_WAIT, cond: COND_NONE, target: STEP_WAIT, ret: 1'b1};
    endcase
    return cw;
  endfunction

endpackage

// ===== hw/rtl/pid_steering_with_lost_timeout_unit.sv =====
// PID steering controller with lost-line timeout, microcoded sequencer top level.
// Depends on psl_pkg, psl_div and assert_macros.svh.
//
// Usage: one input word per camera frame on the s_axis channel, one result
// word per input on the m_axis channel. Gains, cruise speed, lost timeout and
// image width are written on the cfg port while the unit is idle.
// Sequence: a found frame runs the error setup, the serial divider for the
// normalized error, then the error, integral, three multiply-accumulate,
// angular setup, scale and emit steps into the result register; a lost frame
// goes from the check step straight to its emit step. A frame is not accepted
// while the last is in progress: the next word can be accepted from the cycle after the current result is loaded.
// The multiply-accumulate of the three PID terms shares one 9x17 multiplier
// over three steps; the division by 100 is a reciprocal multiplication.
// Reset: registers return to their default values, the integral, previous
// error and last-seen time clear, and the sequencer waits for input.
// Stall: the result is held in the output register until taken; the next
// frame is processed meanwhile and waits at its final step for the register.
`include "assert_macros.svh"

module pid_steering_with_lost_timeout_unit import psl_pkg::*; #(
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned TIME_BITS  = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [ADDR_W-1:0]   cfg_addr_i,
  input  logic [CFG_W-1:0]    cfg_wdata_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // ref_center_x, guide_center_x, time_ms, zero fill
  input  logic [((2*COORD_BITS+TIME_BITS+7)/8)*8-1:0] s_axis_tdata,
  // lines_found
  input  logic                s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // linear_speed, angular_rate, steer_error, status, zero fill
  output logic [OUT_W-1:0]    m_axis_tdata
);

  localparam int unsigned MW     = (COORD_BITS > DIV_W) ? COORD_BITS : DIV_W;
  localparam int unsigned ACC_W  = 27;
  localparam int unsigned PROD_W = 26;
  localparam int unsigned RECIP_SH = 25;
  localparam logic [ACC_W-1:0] ANG_LIM = ACC_W'(32768 * 100);
  localparam logic [20:0] RECIP_25 = 21'd1342178;
  localparam logic signed [Q_W-1:0] QMAX = 16'sd32767;
  localparam logic signed [Q_W-1:0] THRESH = 16'sd655;

  // configuration
  logic [7:0]  gain_p_q, gain_d_q;
  logic [6:0]  gain_i_q, cruise_q;
  logic [15:0] timeout_q;
  logic [11:0] width_q;

  // sequencer
  logic [PC_W-1:0] pc_q, pc_d;
  ucode_t          cw;
  logic            take;
  logic            in_acc;
  logic            out_busy;

  // input hold
  logic                  found_q;
  logic [COORD_BITS-1:0] refx_q, guidex_q;
  logic [TIME_BITS-1:0]  time_q;

  // datapath
  logic                    neg_q, ovf_q;
  logic signed [Q_W-1:0]   err_q, integ_new_q;
  logic signed [Q_W:0]     dif_q;
  logic signed [ACC_W-1:0] acc_q;
  logic [19:0]             amag_q;
  logic signed [Q_W-1:0]   ang_q;
  logic signed [Q_W-1:0]   integral_q, prev_q;
  logic [TIME_BITS-1:0]    last_q;
  logic                    out_valid_q;
  logic [OUT_W-1:0]        out_data_q;

  logic [COORD_BITS:0]     diff;
  logic                    diff_neg;
  logic [COORD_BITS-1:0]   diff_mag;
  logic [MW-1:0]           mag_ext, half_ext;
  logic [DIV_W-1:0]        half;
  logic signed [Q_W:0]     isum;
  logic signed [Q_W-1:0]   isat;
  logic                    acc_neg;
  logic [ACC_W-1:0]        acc_mag;
  logic [7:0]              mgain;
  logic signed [Q_W:0]     mopnd;
  logic signed [PROD_W-1:0] prod;
  logic [40:0]             ang_prod;
  logic [2:0]              status_f, status_l;
  logic [TIME_BITS-1:0]    elapsed;

  div_ctl_t         div_ctl;
  logic [DIV_W-1:0] div_rem0, div_dvs;
  logic [QUO_W-1:0] div_low, quot;
  logic             div_busy;

  function automatic logic signed [Q_W-1:0] signed_q(input logic neg, input logic ovf,
                                                      input logic [QUO_W-1:0] q);
    logic signed [Q_W-1:0] m;
    m = ovf ? QMAX : $signed({1'b0, q});
    return neg ? -m : m;
  endfunction

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q  <= 8'd50;
      gain_i_q  <= 7'd0;
      gain_d_q  <= 8'd10;
      cruise_q  <= 7'd30;
      timeout_q <= 16'd3000;
      width_q   <= 12'd640;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_GAIN_P:       gain_p_q  <= cfg_wdata_i[7:0];
        REG_GAIN_I:       gain_i_q  <= cfg_wdata_i[6:0];
        REG_GAIN_D:       gain_d_q  <= cfg_wdata_i[7:0];
        REG_CRUISE_SPEED: cruise_q  <= cfg_wdata_i[6:0];
        REG_LOST_TIMEOUT: timeout_q <= cfg_wdata_i[15:0];
        REG_IMAGE_WIDTH:  width_q   <= cfg_wdata_i[11:0];
        default: ;
      endcase
    end
  end

  // sequencer
  assign cw            = ucode_rom(pc_q);
  assign s_axis_tready = cw.op == OP_WAIT;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_busy      = out_valid_q && !m_axis_tready;

  always_comb begin
    unique case (cw.cond)
      COND_NONE:      take = 1'b0;
      COND_NO_ACCEPT: take = !in_acc;
      COND_LOST:      take = !found_q;
      COND_DIV_BUSY:  take = div_busy;
      COND_OUT_BUSY:  take = out_busy;
      default:        take = 1'b0;
    endcase
    if (take) begin
      pc_d = cw.target;
    end else if (cw.ret) begin
      pc_d = STEP_WAIT;
    end else begin
      pc_d = pc_q + 1'b1;
    end
  end

  // error setup
  assign diff     = {1'b0, refx_q} - {1'b0, guidex_q};
  assign diff_neg = diff[COORD_BITS];
  assign diff_mag = diff_neg ? COORD_BITS'(-diff) : diff[COORD_BITS-1:0];
  assign half     = (width_q[11:1] == '0) ? DIV_W'(1) : width_q[11:1];
  assign mag_ext  = MW'(diff_mag);
  assign half_ext = MW'(half);

  // integral and angular setup
  assign isum = {integral_q[Q_W-1], integral_q} + {err_q[Q_W-1], err_q};
  assign isat = (isum > 17'sd32767)  ? QMAX :
                (isum < -17'sd32767) ? -QMAX : isum[Q_W-1:0];
  assign acc_neg = acc_q[ACC_W-1];
  assign acc_mag = acc_neg ? ACC_W'(-acc_q) : ACC_W'(acc_q);

  // shared multiplier
  always_comb begin
    case (cw.op)
      OP_MAC_I: begin
        mgain = {1'b0, gain_i_q};
        mopnd = {integ_new_q[Q_W-1], integ_new_q};
      end
      OP_MAC_D: begin
        mgain = gain_d_q;
        mopnd = dif_q;
      end
      default: begin
        mgain = gain_p_q;
        mopnd = {err_q[Q_W-1], err_q};
      end
    endcase
  end
  assign prod = $signed({1'b0, mgain}) * mopnd;

  // divide by 100: drop two bits, then multiply by the reciprocal of 25
  assign ang_prod = amag_q * RECIP_25;

  // divider operands
  always_comb begin
    div_ctl.load = (cw.op == OP_SETUP_ERR) && found_q;
    div_ctl.step = cw.op == OP_DIV;
    div_rem0     = mag_ext[DIV_W-1:0];
    div_low      = '0;
    div_dvs      = half;
  end

  psl_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (div_ctl),
    .rem0_i    (div_rem0),
    .low_i     (div_low),
    .divisor_i (div_dvs),
    .quot_o    (quot),
    .busy_o    (div_busy)
  );

  // results
  assign status_f = (err_q > THRESH) ? ST_RIGHT : (err_q < -THRESH) ? ST_LEFT : ST_CENTER;
  assign elapsed  = time_q - last_q;
  assign status_l = (elapsed > TIME_BITS'(timeout_q)) ? ST_STOPPED : ST_SEARCHING;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= STEP_WAIT;
      out_valid_q <= 1'b0;
      integral_q  <= '0;
      prev_q      <= '0;
      last_q      <= '0;
    end else begin
      pc_q <= pc_d;
      if ((cw.op == OP_EMIT_FOUND) && !out_busy) begin
        out_valid_q <= 1'b1;
        integral_q  <= integ_new_q;
        prev_q      <= err_q;
        last_q      <= time_q;
      end else if ((cw.op == OP_EMIT_LOST) && !out_busy) begin
        out_valid_q <= 1'b1;
        integral_q  <= '0;
        prev_q      <= '0;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (cw.op) inside
      OP_WAIT: begin
        if (in_acc) begin
          found_q  <= s_axis_tuser;
          refx_q   <= s_axis_tdata[COORD_BITS-1:0];
          guidex_q <= s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
          time_q   <= s_axis_tdata[2*COORD_BITS+TIME_BITS-1:2*COORD_BITS];
        end
      end
      OP_SETUP_ERR: begin
        neg_q <= diff_neg;
        ovf_q <= mag_ext >= half_ext;
      end
      OP_ERR: begin
        err_q <= signed_q(neg_q, ovf_q, quot);
      end
      OP_INTEG: begin
        integ_new_q <= isat;
        dif_q       <= {err_q[Q_W-1], err_q} - {prev_q[Q_W-1], prev_q};
        acc_q       <= '0;
      end
      OP_MAC_P, OP_MAC_I, OP_MAC_D: begin
        acc_q <= acc_q + ACC_W'(prod);
      end
      OP_SETUP_ANG: begin
        neg_q  <= acc_neg;
        ovf_q  <= acc_mag >= ANG_LIM;
        amag_q <= acc_mag[QUO_W+6:2];
      end
      OP_SCALE: begin
        ang_q <= signed_q(neg_q, ovf_q, ang_prod[RECIP_SH +: QUO_W]);
      end
      OP_EMIT_FOUND: begin
        if (!out_busy) begin
          out_data_q <= {6'd0, status_f, err_q, ang_q, cruise_q};
        end
      end
      OP_EMIT_LOST: begin
        if (!out_busy) begin
          out_data_q <= {6'd0, status_l, 16'd0, 16'd0, 7'd0};
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  `PSL_ASSERT(a_accept_starts_program, clk_i, rst_ni,
    in_acc |=> (pc_q == STEP_CHECK), "accepted word did not start the program")
  `PSL_ASSERT(a_div_idle_at_wait, clk_i, rst_ni,
    (pc_q == STEP_WAIT) |-> !div_busy, "divider busy while waiting for input")
  `PSL_ASSERT(a_integral_in_range, clk_i, rst_ni,
    integral_q != -16'sd32768, "integral left the saturated range")
  `PSL_ASSERT(a_status_code, clk_i, rst_ni,
    m_axis_tvalid |-> (m_axis_tdata[41:39] <= ST_STOPPED), "status code out of range")

endmodule

// ===== hw/rtl/psl_div.sv =====
// Restoring serial divider, one quotient bit per step, 15-bit quotient.
// Depends on psl_pkg; the initial remainder must be below the divisor.
module psl_div import psl_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  div_ctl_t         ctl_i,
  input  logic [DIV_W-1:0] rem0_i,
  input  logic [QUO_W-1:0] low_i,
  input  logic [DIV_W-1:0] divisor_i,
  output logic [QUO_W-1:0] quot_o,
  output logic             busy_o
);

  logic [DIV_W-1:0] rem_q, rem_d;
  logic [QUO_W-1:0] low_q, low_d;
  logic [QUO_W-1:0] quot_q, quot_d;
  logic [DIV_W-1:0] dvs_q, dvs_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_W:0]   trial;
  logic             qbit;

  assign trial = {rem_q, low_q[QUO_W-1]};
  assign qbit  = trial >= {1'b0, dvs_q};

  always_comb begin
    rem_d  = rem_q;
    low_d  = low_q;
    quot_d = quot_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    if (ctl_i.load) begin
      rem_d  = rem0_i;
      low_d  = low_i;
      dvs_d  = divisor_i;
      quot_d = '0;
      cnt_d  = '0;
    end else if (ctl_i.step) begin
      rem_d  = qbit ? DIV_W'(trial - {1'b0, dvs_q}) : DIV_W'(trial);
      low_d  = {low_q[QUO_W-2:0], 1'b0};
      quot_d = {quot_q[QUO_W-2:0], qbit};
      if (cnt_q != DIV_LAST) begin
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= DIV_LAST;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    low_q  <= low_d;
    quot_q <= quot_d;
    dvs_q  <= dvs_d;
  end

  assign quot_o = quot_q;
  assign busy_o = cnt_q != DIV_LAST;

endmodule

// ===== test/tb_top.sv =====
// Testbench for pid_steering_with_lost_timeout_unit: streams camera frames through the
// unit and checks every result word against a cycle-free steering predictor.
// Depends on psl_pkg and the unit RTL.
module tb_top import psl_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned S_W = ((2*12 + 32 + 7) / 8) * 8;
  localparam longint Q_LIM = 32767;
  localparam longint DEADBAND = 655;
  localparam int unsigned LIMIT = 1_000_000;
  localparam logic [ADDR_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [ADDR_W-1:0] REG_SPARE_B = 3'd7;

  typedef struct packed {
    logic        found;
    logic [11:0] ref_x;
    logic [11:0] guide_x;
    logic [31:0] stamp;
  } frame_t;

  typedef struct packed {
    logic [6:0]            speed;
    logic signed [Q_W-1:0] angular;
    logic signed [Q_W-1:0] err;
    logic [2:0]            status;
  } steer_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [ADDR_W-1:0] cfg_addr_i = '0;
  logic [CFG_W-1:0] cfg_wdata_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  // ref_center_x, guide_center_x, time_ms
  logic [S_W-1:0] s_axis_tdata = '0;
  // lines_found
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  // linear_speed, angular_rate, steer_error, status, zero fill
  logic [OUT_W-1:0] m_axis_tdata;

  // predictor copy of the registers and controller memory
  logic [7:0] kp = 8'd50;
  logic [6:0] ki = 7'd0;
  logic [7:0] kd = 8'd10;
  logic [6:0] cruise = 7'd30;
  logic [15:0] lost_limit = 16'd3000;
  logic [11:0] roi_width = 12'd640;
  logic signed [Q_W-1:0] prev_err = '0;
  logic signed [Q_W-1:0] err_sum = '0;
  logic [31:0] seen_at = '0;

  frame_t frame_q[$];
  steer_t steer_q[$];
  frame_t live_frame;
  logic frame_live = 1'b0;
  int gap_left = 0;
  int burst_left = 0;
  int stall_left = 0;
  int stall_mode = 0;
  int mismatches = 0;
  int unsigned cycles = 0;
  logic [31:0] gen_time = '0;
  logic [31:0] gen_seen = '0;

  pid_steering_with_lost_timeout_unit u_dut (.*);

  always #2 clk_i = ~clk_i;

  function automatic longint clamp_q(input longint v);
    if (v > Q_LIM) return Q_LIM;
    if (v < -Q_LIM) return -Q_LIM;
    return v;
  endfunction

  function automatic steer_t steer_predict(input frame_t f);
    steer_t r;
    longint half, e, integ, acc;
    logic [31:0] elapsed;
    r = '0;
    if (f.found) begin
      half = longint'(roi_width) / 2;
      if (half < 1) half = 1;
      e = clamp_q((longint'(f.ref_x) - longint'(f.guide_x)) * 32768 / half);
      integ = clamp_q(longint'(err_sum) + e);
      acc = longint'(kp) * e + longint'(ki) * integ + longint'(kd) * (e - longint'(prev_err));
      r.angular = Q_W'(clamp_q(acc / 100));
      r.err = Q_W'(e);
      r.speed = cruise;
      if (e > DEADBAND) r.status = ST_RIGHT;
      else if (e < -DEADBAND) r.status = ST_LEFT;
      else r.status = ST_CENTER;
      err_sum = Q_W'(integ);
      prev_err = Q_W'(e);
      seen_at = f.stamp;
    end else begin
      elapsed = f.stamp - seen_at;
      r.status = (elapsed > {16'd0, lost_limit}) ? ST_STOPPED : ST_SEARCHING;
      err_sum = '0;
      prev_err = '0;
    end
    return r;
  endfunction

  always @(posedge clk_i) begin : drv
    logic push;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      push = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        steer_q = {steer_q, steer_predict(live_frame)};
        push = 1'b0;
      end
      if (!push) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (frame_q.size() > 0) begin
          live_frame = frame_q.pop_front();
          s_axis_tdata <= S_W'({live_frame.stamp, live_frame.guide_x, live_frame.ref_x});
          s_axis_tuser <= live_frame.found;
          push = 1'b1;
          if (burst_left == 0) begin
            burst_left = $urandom_range(0, 40);
            case ($urandom_range(0, 3))
              0: gap_left = 0;
              1: gap_left = $urandom_range(1, 3);
              2: gap_left = $urandom_range(4, 25);
              default: gap_left = 0;
            endcase
          end else begin
            burst_left--;
          end
        end
      end
      frame_live = push;
      s_axis_tvalid <= push;
    end
  end

  always @(posedge clk_i) begin : mon
    steer_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.speed = m_axis_tdata[6:0];
      got.angular = m_axis_tdata[7 +: Q_W];
      got.err = m_axis_tdata[7 + Q_W +: Q_W];
      got.status = m_axis_tdata[7 + 2*Q_W +: 3];
      if (steer_q.size() == 0) begin
        $error("result word with no frame pending");
        mismatches++;
      end else begin
        want = steer_q.pop_front();
        if (got.speed !== want.speed) begin
          $error("linear_speed: expected %0d, got %0d", want.speed, got.speed);
          mismatches++;
        end
        if (got.angular !== want.angular) begin
          $error("angular_rate: expected %0d, got %0d", want.angular, got.angular);
          mismatches++;
        end
        if (got.err !== want.err) begin
          $error("steer_error: expected %0d, got %0d", want.err, got.err);
          mismatches++;
        end
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          mismatches++;
        end
      end
    end
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(16, 300);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= 1'($urandom_range(0, 1));
      2: m_axis_tready <= ($urandom_range(0, 7) == 0);
      default: m_axis_tready <= ~m_axis_tready;
    endcase
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic write_reg(input logic [ADDR_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_GAIN_P:       kp = val[7:0];
      REG_GAIN_I:       ki = val[6:0];
      REG_GAIN_D:       kd = val[7:0];
      REG_CRUISE_SPEED: cruise = val[6:0];
      REG_LOST_TIMEOUT: lost_limit = val;
      REG_IMAGE_WIDTH:  roi_width = val[11:0];
      default: ;
    endcase
  endtask

  task automatic add_frame(input logic found, input logic [11:0] rx, input logic [11:0] gx,
                           input logic [31:0] ts);
    frame_t f;
    f = '{found: found, ref_x: rx, guide_x: gx, stamp: ts};
    frame_q = {frame_q, f};
    gen_time = ts;
    if (found) gen_seen = ts;
  endtask

  // hold until every frame is sent and every result word is back
  task automatic settle(input int tail);
    while (frame_q.size() != 0 || frame_live || steer_q.size() != 0) @(posedge clk_i);
    repeat (tail) @(posedge clk_i);
  endtask

  function automatic logic [CFG_W-1:0] pick_val(input int hi, input int top);
    case ($urandom_range(0, 3))
      0: return '0;
      1: return CFG_W'(top);
      2: return CFG_W'($urandom_range(0, hi));
      default: return CFG_W'($urandom);
    endcase
  endfunction

  task automatic random_setup();
    logic [CFG_W-1:0] w;
    write_reg(REG_GAIN_P, pick_val(200, 255));
    write_reg(REG_GAIN_I, pick_val(100, 127));
    write_reg(REG_GAIN_D, pick_val(200, 255));
    write_reg(REG_CRUISE_SPEED, pick_val(100, 127));
    case ($urandom_range(0, 3))
      0: w = '0;
      1: w = 16'hFFFF;
      default: w = CFG_W'($urandom_range(0, 300));
    endcase
    write_reg(REG_LOST_TIMEOUT, w);
    case ($urandom_range(0, 5))
      0: w = CFG_W'($urandom_range(2, 20));
      1: w = 16'd4095;
      2: w = CFG_W'($urandom_range(0, 1));
      default: w = CFG_W'($urandom_range(2, 4095));
    endcase
    write_reg(REG_IMAGE_WIDTH, w);
    if ($urandom_range(0, 1) == 1) write_reg(REG_SPARE_B, CFG_W'($urandom));
  endtask

  task automatic random_phase(input int n);
    logic found;
    logic [11:0] rx, gx;
    logic [31:0] ts;
    for (int k = 0; k < n; k++) begin
      found = ($urandom_range(0, 4) != 0);
      case ($urandom_range(0, 7))
        0: begin
          rx = 12'($urandom);
          gx = 12'($urandom);
        end
        1: begin
          rx = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
          gx = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
        end
        default: begin
          rx = 12'($urandom);
          gx = rx + 12'($urandom_range(0, 80)) - 12'd40;
        end
      endcase
      if (found) begin
        ts = ($urandom_range(0, 15) == 0) ? $urandom : gen_time + $urandom_range(1, 60);
      end else begin
        case ($urandom_range(0, 3))
          0: ts = gen_seen + {16'd0, lost_limit} + $urandom_range(0, 2) - 32'd1;
          1: ts = $urandom;
          default: ts = gen_time + $urandom_range(1, 60);
        endcase
      end
      add_frame(found, rx, gx, ts);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: lost before any found frame, timeout boundary, saturation, wrap
    add_frame(1'b0, 12'd0, 12'd0, 32'd0);
    add_frame(1'b0, 12'd10, 12'd20, 32'd3000);
    add_frame(1'b0, 12'd0, 12'd0, 32'd3001);
    add_frame(1'b1, 12'd320, 12'd320, 32'd5000);
    add_frame(1'b1, 12'd4095, 12'd0, 32'd5010);
    add_frame(1'b1, 12'd0, 12'd4095, 32'd5020);
    add_frame(1'b1, 12'd326, 12'd320, 32'd5030);
    add_frame(1'b1, 12'd327, 12'd320, 32'd5040);
    add_frame(1'b1, 12'd313, 12'd320, 32'd5050);
    add_frame(1'b0, 12'd0, 12'd0, 32'd8050);
    add_frame(1'b0, 12'd0, 12'd0, 32'd8051);
    add_frame(1'b1, 12'd4095, 12'd4095, 32'hFFFF_FFFF);
    add_frame(1'b0, 12'd0, 12'd0, 32'd100);
    add_frame(1'b0, 12'd0, 12'd0, 32'hFFFF_FFFE);
    settle(8);

    // maximum gains, zero timeout, deadband edge at exactly 655
    write_reg(REG_GAIN_P, 16'd255);
    write_reg(REG_GAIN_I, 16'd127);
    write_reg(REG_GAIN_D, 16'd255);
    write_reg(REG_CRUISE_SPEED, 16'd127);
    write_reg(REG_LOST_TIMEOUT, 16'd0);
    write_reg(REG_IMAGE_WIDTH, 16'd100);
    add_frame(1'b1, 12'd51, 12'd50, 32'd200);
    add_frame(1'b1, 12'd49, 12'd50, 32'd210);
    add_frame(1'b1, 12'd52, 12'd50, 32'd220);
    for (int k = 0; k < 3; k++) add_frame(1'b1, 12'd150, 12'd50, 32'd230 + k);
    add_frame(1'b1, 12'd0, 12'd4095, 32'd240);
    add_frame(1'b0, 12'd0, 12'd0, 32'd240);
    add_frame(1'b0, 12'd0, 12'd0, 32'd241);
    settle(8);

    // narrow image: half width forced to one
    write_reg(REG_IMAGE_WIDTH, 16'd0);
    write_reg(REG_GAIN_P, 16'd0);
    write_reg(REG_GAIN_D, 16'd0);
    write_reg(REG_LOST_TIMEOUT, 16'hFFFF);
    write_reg(REG_SPARE_A, 16'hFFFF);
    write_reg(REG_SPARE_B, 16'hFFFF);
    add_frame(1'b1, 12'd5, 12'd5, 32'd300);
    add_frame(1'b1, 12'd6, 12'd5, 32'd301);
    add_frame(1'b1, 12'd5, 12'd6, 32'd302);
    settle(8);
    write_reg(REG_IMAGE_WIDTH, 16'd1);
    add_frame(1'b1, 12'd4095, 12'd0, 32'd303);
    add_frame(1'b0, 12'd0, 12'd0, 32'd303 + 32'd65536);
    settle(8);

    for (int k = 0; k < 6; k++) begin
      random_setup();
      random_phase(160);
      settle(8);
    end
    settle(50);

    if (mismatches == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/psl_pkg.sv
hw/rtl/psl_div.sv
hw/rtl/pid_steering_with_lost_timeout_unit.sv
test/tb_top.sv
